### rtl/sed_pkg.sv
// ----------------------------------------------------------------------------
// sed_pkg
// Shared types, codes and helpers for the string escape decoder.
// ----------------------------------------------------------------------------
package sed_pkg;

  // Result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_ESCAPE  = 2'd0;
  localparam logic [1:0] ERR_HEX     = 2'd1;
  localparam logic [1:0] ERR_UNICODE = 2'd2;
  localparam logic [1:0] ERR_UNTERM  = 2'd3;

  // Characters of interest
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_N  = 8'h6e;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // UTF-8 limits and marks
  localparam logic [15:0] UTF8_MAX1 = 16'h007f;
  localparam logic [15:0] UTF8_MAX2 = 16'h07ff;
  localparam logic [7:0]  UTF8_LEAD2 = 8'hc0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'he0;
  localparam logic [7:0]  UTF8_CONT  = 8'h80;
  localparam logic [7:0]  UTF8_LOW6  = 8'h3f;

  // Most results one input byte can cause
  localparam int unsigned MAX_RESULTS = 4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [1:0] error_code;
  } sed_result_t;

  // One request's worth of results, slot 0 first
  typedef struct packed {
    logic [2:0]                         count;
    sed_result_t [MAX_RESULTS-1:0]      res;
  } sed_burst_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } sed_q_status_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] nibble;
  } sed_hex_t;

  // Decode one ASCII hex digit
  function automatic sed_hex_t hex_digit(input logic [7:0] b);
    sed_hex_t h;
    h.valid  = 1'b1;
    h.nibble = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.nibble = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.nibble = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.nibble = 4'(b - 8'h37);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

  // Append one result to a burst, dropping it once the burst is full
  function automatic sed_burst_t add_result(input sed_burst_t b, input logic [1:0] kind,
                                            input logic [7:0] value,
                                            input logic [1:0] code);
    sed_burst_t r;
    r = b;
    if (b.count < 3'(MAX_RESULTS)) begin
      r.res[b.count[1:0]].kind       = kind;
      r.res[b.count[1:0]].value      = value;
      r.res[b.count[1:0]].error_code = code;
      r.count                        = b.count + 3'd1;
    end
    return r;
  endfunction

endpackage

### rtl/sed_front.sv
// ----------------------------------------------------------------------------
// sed_front
// Accepts raw string bytes, tracks the escape mode and builds the burst of
// results each byte causes.
// ----------------------------------------------------------------------------
module sed_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             data_byte,
  input  logic                   final_byte,
  input  sed_pkg::sed_q_status_t q_status,
  output logic                   push,
  output sed_pkg::sed_burst_t    burst
);

  typedef enum logic [5:0] {
    MODE_PLAIN     = 6'b000001,
    MODE_ESC       = 6'b000010,
    MODE_OCT       = 6'b000100,
    MODE_HEX_FIRST = 6'b001000,
    MODE_HEX       = 6'b010000,
    MODE_UNI       = 6'b100000
  } mode_t;

  mode_t       mode, mode_next;
  logic [15:0] acc, acc_next;
  logic [2:0]  digits, digits_next;
  logic        latched, latched_next;

  logic             accept;
  logic             do_plain;
  logic             closed;
  logic             err;
  logic             is_oct;
  sed_pkg::sed_hex_t hx;
  logic [15:0]      oct_acc;
  logic [15:0]      uni_cp;
  logic [2:0]       digits_inc;
  sed_pkg::sed_burst_t b;

  // Stall only on a full queue
  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  assign hx         = sed_pkg::hex_digit(data_byte);
  assign is_oct     = (data_byte[7:3] == 5'b00110);
  assign oct_acc    = {acc[12:0], data_byte[2:0]};
  assign uni_cp     = {acc[11:0], hx.nibble};
  assign digits_inc = digits + 3'd1;

  // Decode one byte against the current mode
  always_comb begin
    mode_next    = mode;
    acc_next     = acc;
    digits_next  = digits;
    latched_next = latched;
    do_plain     = 1'b0;
    closed       = 1'b0;
    err          = 1'b0;
    b            = '0;

    if (latched) begin
      // Drop everything until a final request
      if (final_byte) begin
        mode_next    = MODE_PLAIN;
        acc_next     = '0;
        digits_next  = '0;
        latched_next = 1'b0;
      end
    end else begin
      unique case (mode)
        MODE_ESC: begin
          mode_next = MODE_PLAIN;
          priority if (data_byte == sed_pkg::CH_LOW_R) begin
            b = sed_pkg::add_result(b, sed_pkg::KIND_BYTE, sed_pkg::CH_CR, sed_pkg::ERR_ESCAPE);
          end else if (data_byte == sed_pkg::CH_LOW_N) begin
            b = sed_pkg::add_result(b, sed_pkg::KIND_BYTE, sed_pkg::CH_LF, sed_pkg::ERR_ESCAPE);
          end else if (data_byte == sed_pkg::CH_LOW_T) begin
            b = sed_pkg::add_result(b, sed_pkg::KIND_BYTE, sed_pkg::CH_TAB, sed_pkg::ERR_ESCAPE);
          end else if (data_byte == sed_pkg::CH_BSLASH || data_byte == sed_pkg::CH_QUOTE) begin
            b = sed_pkg::add_result(b, sed_pkg::KIND_BYTE, data_byte, sed_pkg::ERR_ESCAPE);
          end else if (is_oct) begin
            acc_next    = {13'd0, data_byte[2:0]};
            digits_next = 3'd1;
            mode_next   = MODE_OCT;
          end else if (data_byte == sed_pkg::CH_LOW_X) begin
            mode_next = MODE_HEX_FIRST;
          end else if (data_byte == sed_pkg::CH_LOW_U) begin
            acc_next    = '0;
            digits_next = '0;
            mode_next   = MODE_UNI;
          end else begin
            b   = sed_pkg::add_result(b, sed_pkg::KIND_ERROR, 8'd0, sed_pkg::ERR_ESCAPE);
            err = 1'b1;
          end
        end
        MODE_OCT: begin
          if (is_oct) begin
            acc_next    = oct_acc;
            digits_next = digits_inc;
            if (digits_inc >= 3'd3) begin
              b = sed_pkg::add_result(b, sed_pkg::KIND_BYTE, oct_acc[7:0], sed_pkg::ERR_ESCAPE);
              mode_next = MODE_PLAIN;
            end
          end else begin
            b = sed_pkg::add_result(b, sed_pkg::KIND_BYTE, acc[7:0], sed_pkg::ERR_ESCAPE);
            do_plain = 1'b1;
          end
        end
        MODE_HEX_FIRST: begin
          if (!hx.valid) begin
            b   = sed_pkg::add_result(b, sed_pkg::KIND_ERROR, 8'd0, sed_pkg::ERR_HEX);
            err = 1'b1;
          end else begin
            acc_next    = {12'd0, hx.nibble};
            digits_next = 3'd1;
            mode_next   = MODE_HEX;
          end
        end
        MODE_HEX: begin
          if (hx.valid) begin
            b = sed_pkg::add_result(b, sed_pkg::KIND_BYTE, {acc[3:0], hx.nibble},
                                    sed_pkg::ERR_ESCAPE);
            mode_next = MODE_PLAIN;
          end else begin
            b = sed_pkg::add_result(b, sed_pkg::KIND_BYTE, acc[7:0], sed_pkg::ERR_ESCAPE);
            do_plain = 1'b1;
          end
        end
        MODE_UNI: begin
          if (!hx.valid) begin
            b   = sed_pkg::add_result(b, sed_pkg::KIND_ERROR, 8'd0, sed_pkg::ERR_UNICODE);
            err = 1'b1;
          end else begin
            acc_next    = uni_cp;
            digits_next = digits_inc;
            if (digits_inc >= 3'd4) begin
              // Encode the code point as UTF-8
              if (uni_cp <= sed_pkg::UTF8_MAX1) begin
                b = sed_pkg::add_result(b, sed_pkg::KIND_BYTE, uni_cp[7:0], sed_pkg::ERR_ESCAPE);
              end else if (uni_cp <= sed_pkg::UTF8_MAX2) begin
                b = sed_pkg::add_result(b, sed_pkg::KIND_BYTE,
                                        sed_pkg::UTF8_LEAD2 | {3'd0, uni_cp[10:6]},
                                        sed_pkg::ERR_ESCAPE);
                b = sed_pkg::add_result(b, sed_pkg::KIND_BYTE,
                                        sed_pkg::UTF8_CONT | (uni_cp[7:0] & sed_pkg::UTF8_LOW6),
                                        sed_pkg::ERR_ESCAPE);
              end else begin
                b = sed_pkg::add_result(b, sed_pkg::KIND_BYTE,
                                        sed_pkg::UTF8_LEAD3 | {4'd0, uni_cp[15:12]},
                                        sed_pkg::ERR_ESCAPE);
                b = sed_pkg::add_result(b, sed_pkg::KIND_BYTE,
                                        sed_pkg::UTF8_CONT | (uni_cp[13:6] & sed_pkg::UTF8_LOW6),
                                        sed_pkg::ERR_ESCAPE);
                b = sed_pkg::add_result(b, sed_pkg::KIND_BYTE,
                                        sed_pkg::UTF8_CONT | (uni_cp[7:0] & sed_pkg::UTF8_LOW6),
                                        sed_pkg::ERR_ESCAPE);
              end
              mode_next = MODE_PLAIN;
            end
          end
        end
        MODE_PLAIN: begin
          do_plain = 1'b1;
        end
        default: begin
          do_plain = 1'b1;
        end
      endcase

      // Handle a plain body byte, also the one that ends a numeric escape
      if (do_plain) begin
        mode_next = MODE_PLAIN;
        if (data_byte == sed_pkg::CH_QUOTE) begin
          b      = sed_pkg::add_result(b, sed_pkg::KIND_END, 8'd0, sed_pkg::ERR_ESCAPE);
          closed = 1'b1;
        end else if (data_byte == sed_pkg::CH_BSLASH) begin
          mode_next = MODE_ESC;
        end else begin
          b = sed_pkg::add_result(b, sed_pkg::KIND_BYTE, data_byte, sed_pkg::ERR_ESCAPE);
        end
      end

      // Close out on a final request, or latch an error
      if (final_byte) begin
        if (!err && !closed) begin
          b = sed_pkg::add_result(b, sed_pkg::KIND_ERROR, 8'd0, sed_pkg::ERR_UNTERM);
        end
        mode_next    = MODE_PLAIN;
        acc_next     = '0;
        digits_next  = '0;
        latched_next = 1'b0;
      end else if (err) begin
        mode_next    = MODE_PLAIN;
        acc_next     = '0;
        digits_next  = '0;
        latched_next = 1'b1;
      end
    end
  end

  // Queue only requests that cause results
  assign push  = accept && (b.count != 3'd0);
  assign burst = b;

  // Advance decode state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_PLAIN;
      acc     <= '0;
      digits  <= '0;
      latched <= 1'b0;
    end else if (accept) begin
      mode    <= mode_next;
      acc     <= acc_next;
      digits  <= digits_next;
      latched <= latched_next;
    end
  end

`ifndef SYNTHESIS
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    push |-> (burst.count != 3'd0 && burst.count <= 3'(sed_pkg::MAX_RESULTS)))
    else $error("front pushed a burst with a bad result count");
`endif

endmodule

### rtl/sed_queue.sv
// ----------------------------------------------------------------------------
// sed_queue
// Short queue of result bursts between the front and the back.
// ----------------------------------------------------------------------------
module sed_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  sed_pkg::sed_burst_t    push_burst,
  input  logic                   pop,
  output sed_pkg::sed_burst_t    head,
  output sed_pkg::sed_q_status_t q_status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sed_pkg::sed_burst_t store [DEPTH];
  logic [PTR_W-1:0]    wptr;
  logic [PTR_W-1:0]    rptr;
  logic [CNT_W-1:0]    used;

  assign q_status.full  = (used == CNT_W'(DEPTH));
  assign q_status.empty = (used == '0);
  assign head           = store[rptr];

  // Write the entry at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      store[wptr] <= push_burst;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      used <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        used <= used + 1'b1;
      end else if (pop && !push) begin
        used <= used - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_status.full |-> !push)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_status.empty |-> !pop)
    else $error("queue read while empty");
`endif

endmodule

### rtl/sed_back.sv
// ----------------------------------------------------------------------------
// sed_back
// Takes bursts from the queue and hands their results out one per cycle, while
// the receiver does not stall, through an output register.
// ----------------------------------------------------------------------------
module sed_back (
  input  logic                   clk,
  input  logic                   rst,
  input  sed_pkg::sed_q_status_t q_status,
  input  sed_pkg::sed_burst_t    head,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             kind,
  output logic [7:0]             value,
  output logic [1:0]             error_code,
  output logic                   last_of_run
);

  logic [1:0]          idx;
  logic                load;
  logic                take;
  logic                is_last;
  sed_pkg::sed_result_t cur;

  // Refill the output register when it is empty or being taken
  assign load    = !out_valid || !out_stall;
  assign take    = load && !q_status.empty;
  assign cur     = head.res[idx];
  assign is_last = ({1'b0, idx} == (head.count - 3'd1));
  assign pop     = take && is_last;

  // Step through the slots of the head burst
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= !q_status.empty;
      if (take) begin
        idx <= is_last ? 2'd0 : idx + 2'd1;
      end
    end
  end

  // Hold the payload while stalled
  always_ff @(posedge clk) begin
    if (take) begin
      kind        <= cur.kind;
      value       <= cur.value;
      error_code  <= cur.error_code;
      last_of_run <= is_last;
    end
  end

`ifndef SYNTHESIS
  a_idx_in_burst: assert property (@(posedge clk) disable iff (rst)
    !q_status.empty |-> ({1'b0, idx} < head.count))
    else $error("slot index beyond the head burst");
`endif

endmodule

### rtl/string_escape_decoder_top.sv
// A result passes through the burst queue and then the output register before it
// is valid on the output. Throughput: one byte per cycle; results leave one per
// cycle while the receiver does not stall, so a byte causing up to four results
// (a finished \u escape on a final byte) holds the output port until they drain,
// and the front stalls only when the burst queue fills.
// Reset (rst, synchronous) returns to plain body mode with the error latch and
// the queue cleared.
// ----------------------------------------------------------------------------
// string_escape_decoder_top
// Quoted string body decoder with C escapes and \u to UTF-8 conversion.
// ----------------------------------------------------------------------------
module string_escape_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] value,
  output logic [1:0] error_code,
  output logic       last_of_run
);

  sed_pkg::sed_q_status_t q_status;
  sed_pkg::sed_burst_t    push_burst;
  sed_pkg::sed_burst_t    head;
  logic                   push;
  logic                   pop;

  // Classify bytes and build result bursts
  sed_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .q_status   (q_status),
    .push       (push),
    .burst      (push_burst)
  );

  // Decouple front and back
  sed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_burst (push_burst),
    .pop        (pop),
    .head       (head),
    .q_status   (q_status)
  );

  // Serialise results onto the output
  sed_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_status    (q_status),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .value       (value),
    .error_code  (error_code),
    .last_of_run (last_of_run)
  );

endmodule

### tb/string_escape_decoder_top_tb.sv
// ----------------------------------------------------------------------------
// string_escape_decoder_top_tb
// Self-checking bench for the quoted string body decoder. Directed escapes and
// error cases come first, then random, mostly well-formed string bodies under
// several idle and stall mixes. A behavioural decoder predicts every result,
// and a monitor compares each output request against the oldest prediction.
// ----------------------------------------------------------------------------
module string_escape_decoder_top_tb;

  localparam int CLOCK_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 60;
  localparam int MAX_REPORTS  = 10;
  localparam logic [1:0] NO_CODE = 2'd0;

  // Decoder modes of the behavioural model
  typedef enum logic [2:0] {
    M_PLAIN, M_ESC, M_OCT, M_HEX_FIRST, M_HEX, M_UNI
  } decode_mode_t;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] value;
    logic [1:0] code;
    logic       last;
  } decoded_t;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       in_valid   = 1'b0;
  logic [7:0] data_byte  = 8'h00;
  logic       final_byte = 1'b0;
  logic       out_stall  = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [1:0] kind;
  logic [7:0] value;
  logic [1:0] error_code;
  logic       last_of_run;

  // Model state
  decode_mode_t mode    = M_PLAIN;
  logic [15:0]  acc     = '0;
  logic [2:0]   ndigits = '0;
  logic         latched = 1'b0;

  decoded_t awaited[$];
  decoded_t burst[$];
  int       failures       = 0;
  int       decoded_items  = 0;
  int       cycle_count    = 0;
  int       sender_idle_pct  = 0;
  int       receiver_stall_pct = 0;
  int       hold_req = 0;
  int       hold_ack = 0;
  int       hold_left = 0;

  string_escape_decoder_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .final_byte  (final_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .value       (value),
    .error_code  (error_code),
    .last_of_run (last_of_run)
  );

  always #1 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CLOCK_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Drive the output stall: random, or held high for a long stretch on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_ack  <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_outputs
    decoded_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected result: kind %0d value %02h code %0d last %0b",
                   kind, value, error_code, last_of_run);
      end else begin
        want = awaited.pop_front();
        if (want.kind !== kind || want.value !== value || want.code !== error_code ||
            want.last !== last_of_run) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display({"mismatch: expected kind %0d value %02h code %0d last %0b,",
                      " got %0d %02h %0d %0b"},
                     want.kind, want.value, want.code, want.last,
                     kind, value, error_code, last_of_run);
        end
      end
    end
  end

  function automatic int nibble_of(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  function automatic void emit_result(input logic [1:0] k, input logic [7:0] v,
                                      input logic [1:0] c);
    decoded_t r;
    r.kind  = k;
    r.value = v;
    r.code  = c;
    r.last  = 1'b0;
    if (burst.size() < sed_pkg::MAX_RESULTS) burst.push_back(r);
  endfunction

  function automatic void clear_decoder();
    mode    = M_PLAIN;
    acc     = '0;
    ndigits = '0;
    latched = 1'b0;
  endfunction

  // Handle a byte in plain mode; returns 1 if it closed the string
  function automatic logic plain_byte(input logic [7:0] b);
    mode = M_PLAIN;
    if (b == sed_pkg::CH_QUOTE) begin
      emit_result(sed_pkg::KIND_END, '0, NO_CODE);
      return 1'b1;
    end
    if (b == sed_pkg::CH_BSLASH) mode = M_ESC;
    else emit_result(sed_pkg::KIND_BYTE, b, NO_CODE);
    return 1'b0;
  endfunction

  // Advance the model by one accepted request and queue its results
  task automatic decode_byte(input logic [7:0] b, input logic fin);
    logic        closed;
    logic        err;
    int          h;
    logic [15:0] cp;
    closed = 1'b0;
    err    = 1'b0;
    burst.delete();
    // drop everything while an error is latched, up to a final request
    if (latched) begin
      if (fin) clear_decoder();
      return;
    end
    decoded_items++;
    h = nibble_of(b);
    case (mode)
      M_ESC: begin
        mode = M_PLAIN;
        if (b == sed_pkg::CH_LOW_R) emit_result(sed_pkg::KIND_BYTE, sed_pkg::CH_CR, NO_CODE);
        else if (b == sed_pkg::CH_LOW_N)
          emit_result(sed_pkg::KIND_BYTE, sed_pkg::CH_LF, NO_CODE);
        else if (b == sed_pkg::CH_LOW_T)
          emit_result(sed_pkg::KIND_BYTE, sed_pkg::CH_TAB, NO_CODE);
        else if (b == sed_pkg::CH_BSLASH)
          emit_result(sed_pkg::KIND_BYTE, sed_pkg::CH_BSLASH, NO_CODE);
        else if (b == sed_pkg::CH_QUOTE)
          emit_result(sed_pkg::KIND_BYTE, sed_pkg::CH_QUOTE, NO_CODE);
        else if (b >= "0" && b <= "7") begin
          acc     = 16'(b[2:0]);
          ndigits = 3'd1;
          mode    = M_OCT;
        end else if (b == sed_pkg::CH_LOW_X) begin
          mode = M_HEX_FIRST;
        end else if (b == sed_pkg::CH_LOW_U) begin
          acc     = '0;
          ndigits = '0;
          mode    = M_UNI;
        end else begin
          emit_result(sed_pkg::KIND_ERROR, '0, sed_pkg::ERR_ESCAPE);
          err = 1'b1;
        end
      end
      M_OCT: begin
        if (b >= "0" && b <= "7") begin
          acc     = {acc[12:0], b[2:0]};
          ndigits = ndigits + 3'd1;
          if (ndigits >= 3'd3) begin
            emit_result(sed_pkg::KIND_BYTE, acc[7:0], NO_CODE);
            mode = M_PLAIN;
          end
        end else begin
          // short escape: flush its value, then treat the byte as plain
          emit_result(sed_pkg::KIND_BYTE, acc[7:0], NO_CODE);
          closed = plain_byte(b);
        end
      end
      M_HEX_FIRST: begin
        if (h < 0) begin
          emit_result(sed_pkg::KIND_ERROR, '0, sed_pkg::ERR_HEX);
          err = 1'b1;
        end else begin
          acc     = 16'(h);
          ndigits = 3'd1;
          mode    = M_HEX;
        end
      end
      M_HEX: begin
        if (h >= 0) begin
          emit_result(sed_pkg::KIND_BYTE, {acc[3:0], 4'(h)}, NO_CODE);
          mode = M_PLAIN;
        end else begin
          emit_result(sed_pkg::KIND_BYTE, acc[7:0], NO_CODE);
          closed = plain_byte(b);
        end
      end
      M_UNI: begin
        if (h < 0) begin
          emit_result(sed_pkg::KIND_ERROR, '0, sed_pkg::ERR_UNICODE);
          err = 1'b1;
        end else begin
          cp      = {acc[11:0], 4'(h)};
          acc     = cp;
          ndigits = ndigits + 3'd1;
          // four digits in: encode the code point as UTF-8
          if (ndigits >= 3'd4) begin
            if (cp <= sed_pkg::UTF8_MAX1) begin
              emit_result(sed_pkg::KIND_BYTE, cp[7:0], NO_CODE);
            end else if (cp <= sed_pkg::UTF8_MAX2) begin
              emit_result(sed_pkg::KIND_BYTE, sed_pkg::UTF8_LEAD2 | 8'(cp >> 6), NO_CODE);
              emit_result(sed_pkg::KIND_BYTE,
                          sed_pkg::UTF8_CONT | (cp[7:0] & sed_pkg::UTF8_LOW6), NO_CODE);
            end else begin
              emit_result(sed_pkg::KIND_BYTE, sed_pkg::UTF8_LEAD3 | 8'(cp >> 12), NO_CODE);
              emit_result(sed_pkg::KIND_BYTE,
                          sed_pkg::UTF8_CONT | (8'(cp >> 6) & sed_pkg::UTF8_LOW6), NO_CODE);
              emit_result(sed_pkg::KIND_BYTE,
                          sed_pkg::UTF8_CONT | (cp[7:0] & sed_pkg::UTF8_LOW6), NO_CODE);
            end
            mode = M_PLAIN;
          end
        end
      end
      default: closed = plain_byte(b);
    endcase

    if (fin) begin
      if (!err && !closed) emit_result(sed_pkg::KIND_ERROR, '0, sed_pkg::ERR_UNTERM);
      clear_decoder();
    end else if (err) begin
      latched = 1'b1;
      mode    = M_PLAIN;
      acc     = '0;
      ndigits = '0;
    end

    if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
    foreach (burst[i]) awaited.push_back(burst[i]);
  endtask

  // Offer one request, idling first at random, and predict once accepted
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    final_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(b, fin);
  endtask

  task automatic send_text(input logic [7:0] text[$], input logic fin_last);
    foreach (text[i]) send_byte(text[i], fin_last && (i == text.size() - 1));
  endtask

  // Hold the input idle until every predicted result has come out
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return "0" + 8'(v);
    if ($urandom_range(1) != 0) return "a" + 8'(v - 4'd10);
    return "A" + 8'(v - 4'd10);
  endfunction

  // Build and send random string bodies until n_items bytes have been decoded
  task automatic send_random_text(input int n_items);
    logic [7:0]  text[$];
    logic [7:0]  simple_letters[5];
    logic [7:0]  v;
    logic [15:0] cp;
    int          target;
    int          pick;
    int          n;
    simple_letters = '{sed_pkg::CH_LOW_R, sed_pkg::CH_LOW_N, sed_pkg::CH_LOW_T,
                       sed_pkg::CH_BSLASH, sed_pkg::CH_QUOTE};
    target = decoded_items + n_items;
    while (decoded_items < target) begin
      text.delete();
      repeat ($urandom_range(1, 6)) begin
        pick = $urandom_range(99);
        if (pick < 25) begin
          do v = 8'($urandom_range(255));
          while (v == sed_pkg::CH_QUOTE || v == sed_pkg::CH_BSLASH);
          text.push_back(v);
        end else if (pick < 38) begin
          text.push_back(sed_pkg::CH_BSLASH);
          text.push_back(simple_letters[$urandom_range(4)]);
        end else if (pick < 50) begin
          text.push_back(sed_pkg::CH_BSLASH);
          repeat ($urandom_range(1, 3)) text.push_back("0" + 8'($urandom_range(7)));
        end else if (pick < 62) begin
          text.push_back(sed_pkg::CH_BSLASH);
          text.push_back(sed_pkg::CH_LOW_X);
          repeat ($urandom_range(1, 2)) text.push_back(hex_char(4'($urandom_range(15))));
        end else if (pick < 80) begin
          case ($urandom_range(2))
            0:       cp = 16'($urandom_range(16'h007f));
            1:       cp = 16'($urandom_range(16'h07ff, 16'h0080));
            default: cp = 16'($urandom_range(16'hffff, 16'h0800));
          endcase
          text.push_back(sed_pkg::CH_BSLASH);
          text.push_back(sed_pkg::CH_LOW_U);
          for (int i = 3; i >= 0; i--) text.push_back(hex_char(cp[i*4 +: 4]));
        end else if (pick < 86) begin
          text.push_back(8'($urandom_range(255)));
        end else if (pick < 90) begin
          // unknown escape letter
          do v = 8'($urandom_range(255));
          while (v == sed_pkg::CH_LOW_R || v == sed_pkg::CH_LOW_N ||
                 v == sed_pkg::CH_LOW_T || v == sed_pkg::CH_BSLASH ||
                 v == sed_pkg::CH_QUOTE || v == sed_pkg::CH_LOW_X ||
                 v == sed_pkg::CH_LOW_U || (v >= "0" && v <= "7"));
          text.push_back(sed_pkg::CH_BSLASH);
          text.push_back(v);
        end else if (pick < 95) begin
          do v = 8'($urandom_range(255)); while (nibble_of(v) >= 0);
          text.push_back(sed_pkg::CH_BSLASH);
          text.push_back(sed_pkg::CH_LOW_X);
          text.push_back(v);
        end else begin
          n = $urandom_range(3);
          text.push_back(sed_pkg::CH_BSLASH);
          text.push_back(sed_pkg::CH_LOW_U);
          repeat (n) text.push_back(hex_char(4'($urandom_range(15))));
          do v = 8'($urandom_range(255)); while (nibble_of(v) >= 0);
          text.push_back(v);
        end
      end
      if ($urandom_range(99) < 75) text.push_back(sed_pkg::CH_QUOTE);
      send_text(text, $urandom_range(99) < 60);
    end
  endtask

  task automatic test_plain_bytes();
    send_text('{8'h00, 8'hff, sed_pkg::CH_QUOTE}, 1'b0);
  endtask

  task automatic test_octal_escapes();
    // three digits with the value cut to 8 bits, then one digit ended by a quote
    send_text('{sed_pkg::CH_BSLASH, "7", "7", "7"}, 1'b0);
    send_text('{sed_pkg::CH_BSLASH, "5", sed_pkg::CH_QUOTE}, 1'b0);
  endtask

  task automatic test_hex_escapes();
    send_text('{sed_pkg::CH_BSLASH, sed_pkg::CH_LOW_X, "A", "z"}, 1'b0);
  endtask

  task automatic test_unicode_escape();
    send_text('{sed_pkg::CH_BSLASH, sed_pkg::CH_LOW_U, "0", "7", "F", "F"}, 1'b0);
  endtask

  task automatic test_error_cases();
    // bad escape latches; bytes up to the final one are ignored
    send_text('{sed_pkg::CH_BSLASH, "q", "a", "b"}, 1'b1);
    send_text('{sed_pkg::CH_BSLASH, sed_pkg::CH_LOW_X, "g"}, 1'b1);
    send_text('{sed_pkg::CH_BSLASH, sed_pkg::CH_LOW_U, "z"}, 1'b1);
  endtask

  task automatic test_unterminated();
    // pending hex digit is dropped on the final byte
    send_text('{sed_pkg::CH_BSLASH, sed_pkg::CH_LOW_X, "5"}, 1'b1);
    send_text('{"a"}, 1'b1);
    wait_drain();
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    send_random_text(n);
    wait_drain();
  endtask

  task automatic test_receiver_hold();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_req <= hold_req + 1;
    send_random_text(15);
    wait_drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_plain_bytes();
    test_octal_escapes();
    test_hex_escapes();
    test_unicode_escape();
    test_error_cases();
    test_unterminated();
    test_random_phase(0, 0, 10);
    test_random_phase(67, 0, 10);
    test_random_phase(0, 67, 10);
    test_random_phase(25, 25, 10);
    test_receiver_hold();
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
